### rtl/core/iq_power_meter_attack_decay_core_defines.svh
// Assertion helpers used by the power meter control RTL.
`ifndef IQ_POWER_METER_ATTACK_DECAY_CORE_DEFINES_SVH
`define IQ_POWER_METER_ATTACK_DECAY_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define IPM_AD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define IPM_AD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ipm_ad_pkg.sv
`default_nettype none

package ipm_ad_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int PWR_W        = 2 * SAMPLE_BITS;
  localparam int NORM_STEPS   = $clog2(PWR_W);
  localparam int EXP_W        = $clog2(PWR_W);
  localparam int FRAC_BITS    = 16;
  localparam int LOG_W        = EXP_W + FRAC_BITS;
  localparam int DIFF_W       = LOG_W + 1;
  localparam int MANT_W       = 31;
  localparam int SQR_ITERS    = 16;
  localparam int CNT_W        = $clog2(SQR_ITERS);
  localparam int MUL_W        = 33;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int DB_PER_LOG2  = 50504453;

  localparam logic signed [15:0] LEVEL_RESET = -16'sd30720;
  localparam logic signed [15:0] LEVEL_MIN   = 16'sh8000;
  localparam logic [16:0]        ALPHA_ONE   = 17'h10000;

  localparam logic [1:0] CFG_ATTACK_ALPHA = 2'd0;
  localparam logic [1:0] CFG_DECAY_ALPHA  = 2'd1;
  localparam logic [1:0] CFG_CAL_OFFSET   = 2'd2;

  typedef struct packed {
    logic [16:0]        attack_alpha;
    logic [16:0]        decay_alpha;
    logic signed [15:0] cal_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    attack_alpha: ALPHA_ONE,
    decay_alpha:  ALPHA_ONE,
    cal_offset:   16'sd1280
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_MUL_Q,
    ST_SUM,
    ST_NORM,
    ST_MANT,
    ST_SQR_MUL,
    ST_SQR_UPD,
    ST_SCALE,
    ST_LEVEL,
    ST_ATK_MUL,
    ST_ATK_UPD,
    ST_DEC_UPD,
    ST_PICK,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_I,
    OP_MUL_Q,
    OP_SUM,
    OP_NORM,
    OP_MANT,
    OP_SQR_MUL,
    OP_SQR_UPD,
    OP_SCALE,
    OP_LEVEL,
    OP_ATK_MUL,
    OP_ATK_UPD,
    OP_DEC_UPD,
    OP_PICK,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [CNT_W-1:0] step;
  } dp_cmd_t;

  // Evaluated at elaboration only, for the full-scale reference level.
  function automatic longint unsigned log2_q16_const(input longint unsigned x);
    longint unsigned m;
    longint unsigned frac;
    int              e;
    e    = 0;
    frac = 0;
    for (int k = 1; k < 64; k++) begin
      if (x[k]) begin
        e = k;
      end
    end
    if (e >= 30) begin
      m = x >> (e - 30);
    end else begin
      m = x << (30 - e);
    end
    for (int k = 0; k < FRAC_BITS; k++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    return (longint'(e) << FRAC_BITS) + frac;
  endfunction

  localparam longint unsigned FULL_SCALE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic [LOG_W-1:0] LOG_FS =
    LOG_W'(log2_q16_const(FULL_SCALE * FULL_SCALE));

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  function automatic logic [16:0] clamp_alpha(input logic [16:0] a);
    logic [16:0] r;
    if (a[16] && (a[15:0] != 16'd0)) begin
      r = ALPHA_ONE;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ipm_ad_ctrl.sv
`default_nettype none
`include "iq_power_meter_attack_decay_core_defines.svh"

module ipm_ad_ctrl
  import ipm_ad_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  localparam logic [CNT_W-1:0] NORM_LAST = CNT_W'(NORM_STEPS - 1);
  localparam logic [CNT_W-1:0] SQR_LAST  = CNT_W'(SQR_ITERS - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL_I;
        end
      end
      ST_MUL_I: state_d = ST_MUL_Q;
      ST_MUL_Q: state_d = ST_SUM;
      ST_SUM: begin
        state_d = ST_NORM;
        cnt_d   = '0;
      end
      ST_NORM: begin
        if (cnt_q == NORM_LAST) begin
          state_d = ST_MANT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MANT:    state_d = ST_SQR_MUL;
      ST_SQR_MUL: state_d = ST_SQR_UPD;
      ST_SQR_UPD: begin
        if (cnt_q == SQR_LAST) begin
          state_d = ST_SCALE;
          cnt_d   = '0;
        end else begin
          state_d = ST_SQR_MUL;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ST_SCALE:   state_d = ST_LEVEL;
      ST_LEVEL:   state_d = ST_ATK_MUL;
      ST_ATK_MUL: state_d = ST_ATK_UPD;
      ST_ATK_UPD: state_d = ST_DEC_UPD;
      ST_DEC_UPD: state_d = ST_PICK;
      ST_PICK:    state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.step  = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
        end
      end
      ST_MUL_I:   cmd_o.op = OP_MUL_I;
      ST_MUL_Q:   cmd_o.op = OP_MUL_Q;
      ST_SUM:     cmd_o.op = OP_SUM;
      ST_NORM:    cmd_o.op = OP_NORM;
      ST_MANT:    cmd_o.op = OP_MANT;
      ST_SQR_MUL: cmd_o.op = OP_SQR_MUL;
      ST_SQR_UPD: cmd_o.op = OP_SQR_UPD;
      ST_SCALE:   cmd_o.op = OP_SCALE;
      ST_LEVEL:   cmd_o.op = OP_LEVEL;
      ST_ATK_MUL: cmd_o.op = OP_ATK_MUL;
      ST_ATK_UPD: cmd_o.op = OP_ATK_UPD;
      ST_DEC_UPD: cmd_o.op = OP_DEC_UPD;
      ST_PICK:    cmd_o.op = OP_PICK;
      ST_OUT: begin
        if (out_free) begin
          cmd_o.op = OP_OUT;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `IPM_AD_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && in_ready_o,
    state_q == ST_MUL_I, "An accepted item did not start the power multiply.")
  `IPM_AD_ASSERT_NEXT(a_sqr_loop, clk_i, rst_ni,
    state_q == ST_SQR_UPD && cnt_q != SQR_LAST,
    state_q == ST_SQR_MUL && cnt_q == $past(cnt_q) + 1'b1,
    "The squaring loop skipped or repeated an iteration.")
  `IPM_AD_ASSERT_NOW(a_result_from_out, clk_i, rst_ni, $rose(out_valid_q),
    $past(state_q) == ST_OUT, "A result appeared outside the output step.")
  `IPM_AD_ASSERT_NOW(a_norm_bound, clk_i, rst_ni, state_q == ST_NORM,
    cnt_q <= NORM_LAST, "The normalization step count ran past its end.")

endmodule

`default_nettype wire

### rtl/core/ipm_ad_dp.sv
`default_nettype none

module ipm_ad_dp
  import ipm_ad_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  cfg_t               cfg_i,
  input  logic signed [15:0] i_sample_i,
  input  logic signed [15:0] q_sample_i,
  input  logic               clear_peak_i,
  output logic signed [15:0] average_level_o,
  output logic signed [15:0] peak_level_o
);

  logic signed [SAMPLE_BITS-1:0] i_q, q_q;
  logic                          clear_q;
  logic [PWR_W-1:0]              pwr_q, x_q;
  logic [EXP_W-1:0]              exp_q;
  logic                          zero_q;
  logic [MANT_W-1:0]             m_q;
  logic [FRAC_BITS-1:0]          frac_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [15:0]            level_q, rep_q;
  logic signed [15:0]            avg_out_q, peak_out_q;
  logic signed [31:0]            atk_q, dec_q;
  logic signed [15:0]            peak_q;

  logic signed [MUL_W-1:0]       mul_a, mul_b;
  logic signed [PROD_W-1:0]      prod_d;
  logic [PWR_W-1:0]              pwr_sum;
  logic [CNT_W-1:0]              norm_idx;
  logic [EXP_W-1:0]              norm_sh;
  logic                          top_zero;
  logic [PWR_W+MANT_W-1:0]       mant_ext;
  logic                          sq_bit;
  logic signed [DIFF_W-1:0]      diff;
  logic [PROD_W-1:0]             rnd_scale, rnd_avg;
  logic [31:0]                   avg_step;
  logic signed [32:0]            d_atk, d_dec;
  logic signed [31:0]            chosen;
  logic [32:0]                   chosen_rnd;
  logic signed [15:0]            peak_new;

  assign pwr_sum  = pwr_q + prod_q[PWR_W-1:0];
  assign norm_idx = CNT_W'(NORM_STEPS - 1) - cmd_i.step;
  assign norm_sh  = EXP_W'(1) << norm_idx;
  assign top_zero = (x_q & ~({PWR_W{1'b1}} >> norm_sh)) == '0;
  assign mant_ext = {x_q, {MANT_W{1'b0}}};
  assign sq_bit   = prod_q[2*MANT_W-1];
  assign diff     = {1'b0, exp_q, frac_q} - {1'b0, LOG_FS};
  assign rnd_scale = prod_q + PROD_W'(64'h8000_0000);
  assign rnd_avg   = prod_q + PROD_W'(32'd32768);
  assign avg_step  = rnd_avg[47:16];
  assign d_atk     = {level_q[15], level_q, 16'b0} - {atk_q[31], atk_q};
  assign d_dec     = {level_q[15], level_q, 16'b0} - {dec_q[31], dec_q};
  assign chosen    = (atk_q > dec_q) ? atk_q : dec_q;
  assign chosen_rnd = {chosen[31], chosen} + 33'd32768;
  assign peak_new   = (level_q > peak_q) ? level_q : peak_q;

  // One shared multiplier serves the squares, the log iterations, the dB scale
  // and both averagers.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_I: begin
        mul_a = MUL_W'(i_q);
        mul_b = MUL_W'(i_q);
      end
      OP_MUL_Q: begin
        mul_a = MUL_W'(q_q);
        mul_b = MUL_W'(q_q);
      end
      OP_SQR_MUL: begin
        mul_a = MUL_W'({1'b0, m_q});
        mul_b = MUL_W'({1'b0, m_q});
      end
      OP_SCALE: begin
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'(DB_PER_LOG2);
      end
      OP_ATK_MUL: begin
        mul_a = MUL_W'(d_atk);
        mul_b = MUL_W'({1'b0, cfg_i.attack_alpha});
      end
      OP_ATK_UPD: begin
        mul_a = MUL_W'(d_dec);
        mul_b = MUL_W'({1'b0, cfg_i.decay_alpha});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.op)
      OP_LOAD: begin
        i_q     <= SAMPLE_BITS'($unsigned(i_sample_i));
        q_q     <= SAMPLE_BITS'($unsigned(q_sample_i));
        clear_q <= clear_peak_i;
      end
      OP_MUL_Q: pwr_q <= prod_q[PWR_W-1:0];
      OP_SUM: begin
        x_q    <= pwr_sum;
        exp_q  <= EXP_W'(PWR_W - 1);
        zero_q <= pwr_sum == '0;
      end
      OP_NORM: begin
        if (top_zero) begin
          x_q   <= x_q << norm_sh;
          exp_q <= exp_q - norm_sh;
        end
      end
      OP_MANT: begin
        m_q    <= mant_ext[PWR_W+MANT_W-1 -: MANT_W];
        frac_q <= '0;
      end
      OP_SQR_UPD: begin
        frac_q <= {frac_q[FRAC_BITS-2:0], sq_bit};
        m_q    <= sq_bit ? prod_q[2*MANT_W-1:MANT_W] : prod_q[2*MANT_W-2:MANT_W-1];
      end
      OP_LEVEL: begin
        level_q <= zero_q ? LEVEL_MIN : sat16(40'($signed(rnd_scale[PROD_W-1:32])));
      end
      OP_PICK: rep_q <= sat16(40'($signed(chosen_rnd[32:16])));
      OP_OUT: begin
        avg_out_q  <= sat16(40'(rep_q) + 40'($signed(cfg_i.cal_offset)));
        peak_out_q <= sat16(40'(peak_q) + 40'($signed(cfg_i.cal_offset)));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atk_q  <= 32'(LEVEL_RESET) <<< 16;
      dec_q  <= 32'(LEVEL_RESET) <<< 16;
      peak_q <= LEVEL_RESET;
    end else begin
      case (cmd_i.op)
        OP_ATK_UPD: atk_q <= atk_q + $signed(avg_step);
        OP_DEC_UPD: dec_q <= dec_q + $signed(avg_step);
        OP_PICK: begin
          if (atk_q > dec_q) begin
            dec_q <= atk_q;
          end
          peak_q <= peak_new;
        end
        OP_OUT: begin
          if (clear_q) begin
            peak_q <= LEVEL_RESET;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign average_level_o = avg_out_q;
  assign peak_level_o    = peak_out_q;

endmodule

`default_nettype wire

### rtl/core/iq_power_meter_attack_decay_core.sv
// I/Q power meter with attack/decay smoothing and peak hold.
// Input channel: one complex sample (I, Q) and a clear_peak flag per item,
// accepted on in_valid_i and in_ready_o. Output channel: one item per input
// item carrying the smoothed level and the held peak in 1/256 dB with the
// calibration offset added, on out_valid_o and out_ready_i.
// Configuration: writes on cfg_valid_i are always taken; index 0 and 1 set
// the attack and decay weights, index 2 the calibration offset. Write only
// while no item is in flight.
// Items are handled one at a time: the next item can be taken in the first
// cycle that the result of the last one is valid. The processing time is set
// by the single shared multiplier, mostly by the 16 squaring iterations of
// the logarithm, each a multiply step and an update step.
// A finished result waits in the output register while the next item is
// processed; if it is still not taken, the next item holds in its last step.
// Reset restores the default configuration and sets both averages and the
// peak hold to -120 dB.
`default_nettype none

module iq_power_meter_attack_decay_core
  import ipm_ad_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] i_sample_i,
  input  logic signed [15:0] q_sample_i,
  input  logic               clear_peak_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] average_level_o,
  output logic signed [15:0] peak_level_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ATTACK_ALPHA: cfg_d.attack_alpha = clamp_alpha(cfg_data_i);
        CFG_DECAY_ALPHA:  cfg_d.decay_alpha  = clamp_alpha(cfg_data_i);
        CFG_CAL_OFFSET:   cfg_d.cal_offset   = cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ipm_ad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ipm_ad_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg_q),
    .i_sample_i      (i_sample_i),
    .q_sample_i      (q_sample_i),
    .clear_peak_i    (clear_peak_i),
    .average_level_o (average_level_o),
    .peak_level_o    (peak_level_o)
  );

endmodule

`default_nettype wire

### tb/iq_power_meter_attack_decay_core_test.sv
module iq_power_meter_attack_decay_core_test;
  import ipm_ad_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 56;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 600;

  typedef struct packed {
    logic signed [15:0] avg;
    logic signed [15:0] peak;
  } meter_out_t;

  typedef struct packed {
    logic       given;
    meter_out_t res;
  } known_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [1:0]         idx;
    logic [16:0]        data;
    logic signed [15:0] i_val;
    logic signed [15:0] q_val;
    logic               clr;
    logic               given;
    meter_out_t         res;
  } row_t;

  typedef enum int { SK_ZERO, SK_FULL, SK_SCALED, SK_CORNER } sample_kind_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] i_sample_i;
  logic signed [15:0] q_sample_i;
  logic               clear_peak_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] average_level_o;
  logic signed [15:0] peak_level_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [16:0]        cfg_data_i;

  cfg_t               meter_cfg;
  logic signed [31:0] atk_avg;
  logic signed [31:0] dec_avg;
  logic signed [15:0] held_peak;

  meter_out_t pending_levels[$];
  known_t     known_q[$];

  int mismatches  = 0;
  int results     = 0;
  int sent        = 0;
  int clears      = 0;
  int cfg_writes  = 0;
  int attack_wins = 0;
  int burst_left  = 0;
  bit hold_done   = 1'b0;

  iq_power_meter_attack_decay_core dut (.*);

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic longint log2_fix(input longint unsigned x);
    int              e;
    longint unsigned m;
    longint unsigned frac;
    e = 63;
    while (x[e] == 1'b0) e--;
    if (e >= 30) m = x >> (e - 30);
    else m = x << (30 - e);
    frac = 0;
    repeat (FRAC_BITS) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    return longint'(e) * 65536 + longint'(frac);
  endfunction

  function automatic logic signed [15:0] level_db(input logic signed [15:0] i_val,
                                                  input logic signed [15:0] q_val);
    longint unsigned pwr;
    longint unsigned fs;
    longint          diff;
    pwr = longint'(i_val) * longint'(i_val) + longint'(q_val) * longint'(q_val);
    fs  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    if (pwr == 0) return LEVEL_MIN;
    diff = log2_fix(pwr) - log2_fix(fs * fs);
    return clamp16((diff * DB_PER_LOG2 + (longint'(1) <<< 31)) >>> 32);
  endfunction

  function automatic logic signed [31:0] smooth(input logic signed [31:0] avg,
                                                input logic signed [15:0] lvl,
                                                input logic [16:0] alpha);
    longint a;
    longint d;
    a = longint'(alpha);
    if (alpha > ALPHA_ONE) a = 65536;
    d = longint'(lvl) * 65536 - longint'(avg);
    return 32'(longint'(avg) + ((d * a + 32768) >>> 16));
  endfunction

  function automatic meter_out_t meter_step(input logic signed [15:0] i_val,
                                            input logic signed [15:0] q_val,
                                            input logic clr);
    logic signed [15:0] lvl;
    logic signed [31:0] chosen;
    logic signed [15:0] rep;
    meter_out_t         r;
    lvl     = level_db(i_val, q_val);
    atk_avg = smooth(atk_avg, lvl, meter_cfg.attack_alpha);
    dec_avg = smooth(dec_avg, lvl, meter_cfg.decay_alpha);
    if (atk_avg > dec_avg) begin
      dec_avg = atk_avg;
      chosen  = atk_avg;
      attack_wins++;
    end else begin
      chosen = dec_avg;
    end
    rep = clamp16((longint'(chosen) + 32768) >>> 16);
    if (lvl > held_peak) held_peak = lvl;
    r.avg  = clamp16(longint'(rep) + longint'(meter_cfg.cal_offset));
    r.peak = clamp16(longint'(held_peak) + longint'(meter_cfg.cal_offset));
    if (clr) held_peak = LEVEL_RESET;
    return r;
  endfunction

  function automatic row_t item_row(input logic signed [15:0] i_val,
                                    input logic signed [15:0] q_val, input logic clr);
    row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.i_val = i_val;
    r.q_val = q_val;
    r.clr   = clr;
    return r;
  endfunction

  function automatic row_t check_row(input logic signed [15:0] i_val,
                                     input logic signed [15:0] q_val, input logic clr,
                                     input logic signed [15:0] avg,
                                     input logic signed [15:0] peak);
    row_t r;
    r          = item_row(i_val, q_val, clr);
    r.given    = 1'b1;
    r.res.avg  = avg;
    r.res.peak = peak;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [1:0] idx, input logic [16:0] data);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic logic [16:0] pick_alpha();
    case ($urandom_range(5, 0))
      0: return 17'd0;
      1: return ALPHA_ONE;
      2: return 17'($urandom_range(131071, 65537));
      3: return 17'($urandom);
      default: return 17'(1 << $urandom_range(14, 4));
    endcase
  endfunction

  function automatic logic signed [15:0] rand_component();
    sample_kind_e kind;
    int           span;
    int           pick;
    pick = $urandom_range(9, 0);
    if (pick == 0) kind = SK_ZERO;
    else if (pick <= 3) kind = SK_FULL;
    else if (pick <= 7) kind = SK_SCALED;
    else kind = SK_CORNER;
    case (kind)
      SK_ZERO: return 16'sd0;
      SK_FULL: return 16'($urandom);
      SK_SCALED: begin
        span = 1 << $urandom_range(14, 0);
        return 16'(int'($urandom_range(2 * span, 0)) - span);
      end
      default: begin
        case ($urandom_range(4, 0))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          3: return 16'sd1;
          default: return 16'sd0;
        endcase
      end
    endcase
  endfunction

  task automatic send_sample(input logic signed [15:0] i_val, input logic signed [15:0] q_val,
                             input logic clr, input known_t known);
    known_q.push_back(known);
    cfg_valid_i  <= 1'b0;
    in_valid_i   <= 1'b1;
    i_sample_i   <= i_val;
    q_sample_i   <= q_val;
    clear_peak_i <= clr;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (clr) clears++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(60, 1)) @(posedge clk_i);
      burst_left = $urandom_range(40, 0);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
  endtask

  task automatic wait_drained();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_levels.size() != 0 || known_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string field, input logic signed [15:0] want,
                                 input logic signed [15:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               field, results, want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    known_t     known;
    meter_out_t predicted;
    meter_out_t oldest;
    meter_out_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ATTACK_ALPHA: meter_cfg.attack_alpha = cfg_data_i;
          CFG_DECAY_ALPHA:  meter_cfg.decay_alpha = cfg_data_i;
          CFG_CAL_OFFSET:   meter_cfg.cal_offset = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        known     = known_q.pop_front();
        predicted = meter_step(i_sample_i, q_sample_i, clear_peak_i);
        if (known.given) predicted = known.res;
        pending_levels.push_back(predicted);
      end
      if (out_valid_o && out_ready_i) begin
        results++;
        got.avg  = average_level_o;
        got.peak = peak_level_o;
        if (pending_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result %0d: average %0d, peak %0d",
                     results, got.avg, got.peak);
          end
        end else begin
          oldest = pending_levels.pop_front();
          if (got.avg !== oldest.avg) report_mismatch("average_level", oldest.avg, got.avg);
          if (got.peak !== oldest.peak) report_mismatch("peak_level", oldest.peak, got.peak);
        end
      end
    end
  end

  initial begin : receiver
    int mode;
    int cyc;
    mode = 0;
    cyc  = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && results >= HOLD_AT) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      if (cyc % 64 == 0) mode = $urandom_range(3, 0);
      cyc++;
      case (mode)
        2: out_ready_i <= 1'($urandom_range(1, 0));
        3: out_ready_i <= ($urandom_range(7, 0) == 0);
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  initial begin : stimulus
    row_t   dir_table[$];
    row_t   row;
    known_t known;
    in_valid_i   <= 1'b0;
    i_sample_i   <= '0;
    q_sample_i   <= '0;
    clear_peak_i <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    rst_ni       <= 1'b0;
    meter_cfg = CFG_RESET;
    atk_avg   = $signed({LEVEL_RESET, 16'h0000});
    dec_avg   = $signed({LEVEL_RESET, 16'h0000});
    held_peak = LEVEL_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    dir_table.push_back(check_row(0, 0, 0, -31488, -29440));
    dir_table.push_back(check_row(32767, 0, 0, 1280, 1280));
    dir_table.push_back(check_row(0, 32767, 1, 1280, 1280));
    dir_table.push_back(check_row(0, 0, 0, -31488, -29440));
    dir_table.push_back(item_row(-32768, -32768, 0));
    dir_table.push_back(item_row(-32768, 32767, 1));
    dir_table.push_back(item_row(1, 0, 0));
    dir_table.push_back(cfg_row(CFG_ATTACK_ALPHA, 17'h1ffff));
    dir_table.push_back(cfg_row(CFG_DECAY_ALPHA, 17'h00000));
    dir_table.push_back(cfg_row(CFG_CAL_OFFSET, 17'h07fff));
    dir_table.push_back(check_row(32767, 0, 0, 32767, 32767));
    dir_table.push_back(check_row(-32768, -32768, 1, 32767, 32767));
    dir_table.push_back(cfg_row(CFG_ATTACK_ALPHA, ALPHA_ONE));
    dir_table.push_back(cfg_row(CFG_DECAY_ALPHA, ALPHA_ONE));
    dir_table.push_back(cfg_row(CFG_CAL_OFFSET, 17'h08000));
    dir_table.push_back(check_row(0, 0, 1, -32768, -32768));
    dir_table.push_back(item_row(-1, -1, 0));
    dir_table.push_back(cfg_row(CFG_ATTACK_ALPHA, 17'h02000));
    dir_table.push_back(cfg_row(CFG_DECAY_ALPHA, 17'h00040));
    dir_table.push_back(cfg_row(CFG_CAL_OFFSET, 17'h00000));
    dir_table.push_back(item_row(20000, -15000, 0));
    dir_table.push_back(item_row(32767, 32767, 0));
    dir_table.push_back(item_row(0, 0, 0));
    dir_table.push_back(item_row(100, -3, 0));
    dir_table.push_back(item_row(21845, -21846, 0));
    dir_table.push_back(item_row(-21846, 21845, 1));
    dir_table.push_back(item_row(0, 1, 0));
    dir_table.push_back(item_row(-32768, 0, 0));

    foreach (dir_table[n]) begin
      row = dir_table[n];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        write_reg(row.idx, row.data);
      end else begin
        known.given = row.given;
        known.res   = row.res;
        send_sample(row.i_val, row.q_val, row.clr, known);
      end
    end

    known = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_reg(CFG_ATTACK_ALPHA, pick_alpha());
      write_reg(CFG_DECAY_ALPHA, pick_alpha());
      case ($urandom_range(3, 0))
        0: write_reg(CFG_CAL_OFFSET, 17'h08000);
        1: write_reg(CFG_CAL_OFFSET, 17'h07fff);
        2: write_reg(CFG_CAL_OFFSET, 17'd1280);
        default: write_reg(CFG_CAL_OFFSET, 17'($urandom_range(65535, 0)));
      endcase
      repeat (PHASE_ITEMS) begin
        send_sample(rand_component(), rand_component(), ($urandom_range(7, 0) == 0), known);
      end
    end
    wait_drained();

    $display("Checked %0d results from %0d samples (%0d peak clears) across %0d register writes.",
             results, sent, clears, cfg_writes);
    $display("Attack average led on %0d samples; long output stall applied: %0d.",
             attack_wins, hold_done);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ipm_ad_pkg.sv
rtl/core/ipm_ad_ctrl.sv
rtl/core/ipm_ad_dp.sv
rtl/core/iq_power_meter_attack_decay_core.sv
tb/iq_power_meter_attack_decay_core_test.sv
